// File: rtl/avrm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic steps for the vector alignment rotation matrix core.
package avrm_pkg;

	localparam int WORD_WIDTH = 16;
	localparam int IN_W = 16;
	localparam int ROW_W = 48;
	localparam int RND_SH = 44 - WORD_WIDTH;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 15;
	localparam int PIPE_DEPTH = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1 + 4;

	localparam logic signed [IN_W-1:0] COS_ONE = 16'sd16384;
	localparam logic [28:0] RAD_ONE = 29'd268435456;
	localparam logic [WORD_WIDTH-1:0] WORD_ONE = WORD_WIDTH'(1) << (WORD_WIDTH - 2);
	localparam logic [WORD_WIDTH-1:0] WORD_ZERO = '0;
	localparam logic [ROW_W-1:0] ID_ROW0 = ROW_W'({WORD_ZERO, WORD_ZERO, WORD_ONE});
	localparam logic [ROW_W-1:0] ID_ROW1 = ROW_W'({WORD_ZERO, WORD_ONE, WORD_ZERO});
	localparam logic [ROW_W-1:0] ID_ROW2 = ROW_W'({WORD_ONE, WORD_ZERO, WORD_ZERO});
	localparam logic signed [47:0] WORD_MAX = 48'((64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1);
	localparam logic signed [47:0] WORD_MIN = -WORD_MAX - 48'sd1;
	localparam logic signed [47:0] RND_HALF = 48'sd1 <<< (RND_SH - 1);

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] root;
	} sqrt_acc_t;

	typedef struct packed {
		logic [46:0] rem;
		logic [DIV_STEPS-1:0] quo;
	} div_acc_t;

	typedef struct packed {
		logic [31:0] abs_x;
		logic [31:0] abs_y;
		logic [31:0] abs_z;
		logic [2:0] neg;
		logic signed [IN_W-1:0] cos;
		logic no_rot;
		logic degen;
	} side_t;

	function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
		logic [34:0] cur;
		logic [34:0] trial;
		sqrt_acc_t r;
		cur = {acc.rem, pair};
		trial = {1'b0, acc.root, 2'b01};
		if (cur >= trial) begin
			r.rem = 33'(cur - trial);
			r.root = {acc.root[30:0], 1'b1};
		end else begin
			r.rem = 33'(cur);
			r.root = {acc.root[30:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_acc_t div_step(div_acc_t acc, logic [46:0] dsh);
		div_acc_t r;
		if (acc.rem >= dsh) begin
			r.rem = acc.rem - dsh;
			r.quo = {acc.quo[DIV_STEPS-2:0], 1'b1};
		end else begin
			r.rem = acc.rem;
			r.quo = {acc.quo[DIV_STEPS-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [WORD_WIDTH-1:0] to_word(logic signed [47:0] v);
		logic signed [47:0] r;
		r = (v + RND_HALF) >>> RND_SH;
		if (r > WORD_MAX) begin
			r = WORD_MAX;
		end else if (r < WORD_MIN) begin
			r = WORD_MIN;
		end
		return r[WORD_WIDTH-1:0];
	endfunction

endpackage

// File: rtl/avrm_ifs.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the vector alignment rotation matrix core.
interface avrm_req_if;
	logic valid;
	logic ready;
	logic signed [avrm_pkg::IN_W-1:0] from_x;
	logic signed [avrm_pkg::IN_W-1:0] from_y;
	logic signed [avrm_pkg::IN_W-1:0] from_z;
	logic signed [avrm_pkg::IN_W-1:0] to_x;
	logic signed [avrm_pkg::IN_W-1:0] to_y;
	logic signed [avrm_pkg::IN_W-1:0] to_z;
	modport source(output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
	modport sink(input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

interface avrm_res_if;
	logic valid;
	logic ready;
	logic [avrm_pkg::ROW_W-1:0] row0_packed;
	logic [avrm_pkg::ROW_W-1:0] row1_packed;
	logic [avrm_pkg::ROW_W-1:0] row2_packed;
	logic rotated;
	logic degenerate;
	modport source(output valid, row0_packed, row1_packed, row2_packed, rotated, degenerate,
		input ready);
	modport sink(input valid, row0_packed, row1_packed, row2_packed, rotated, degenerate,
		output ready);
endinterface

// File: rtl/align_vector_rotation_matrix_core.sv
`timescale 1ns / 1ps
// Top level: pipelined Rodrigues rotation matrix that turns one unit vector onto another.
//
// Channel   Dir  Contents
// req       in   from_x/y/z, to_x/y/z, signed Q2.14
// result    out  row0/1/2_packed (three Q2.14 words each), rotated, degenerate
// cfg       in   cfg_we, cfg_wdata = no_rotation_cosine, signed Q2.14
//
// One request enters per cycle while the result channel is not stalled.
// Most of the pipeline stages are the 32-stage axis length square root and the 15-stage dividers.
// Reset clears the valid bits and sets the cosine limit to 1.0; there is no clearing pass.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module align_vector_rotation_matrix_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [avrm_pkg::IN_W-1:0] cfg_wdata,
	avrm_req_if.sink req,
	avrm_res_if.source result
);

	localparam int N = avrm_pkg::PIPE_DEPTH;

	typedef struct packed {
		logic signed [31:0] fy_tz, fz_ty, fz_tx, fx_tz, fx_ty, fy_tx, fx_tx, fy_ty, fz_tz;
	} prod_t;

	typedef struct packed {
		logic signed [32:0] ax, ay, az;
		logic signed [15:0] cos;
		logic no_rot;
	} axis_t;

	typedef struct packed {
		logic [63:0] sq_x, sq_y, sq_z;
		logic [28:0] cc;
		avrm_pkg::side_t side;
	} sq_t;

	typedef struct packed {
		logic [63:0] len_rad;
		logic [28:0] sin_rad;
		avrm_pkg::sqrt_acc_t len_acc;
		avrm_pkg::sqrt_acc_t sin_acc;
		avrm_pkg::side_t side;
	} sqrt_stage_t;

	typedef struct packed {
		avrm_pkg::div_acc_t qx, qy, qz;
		logic [31:0] len;
		logic [14:0] sin;
		avrm_pkg::side_t side;
	} div_stage_t;

	typedef struct packed {
		logic signed [15:0] ux, uy, uz;
		logic signed [16:0] t;
		logic signed [15:0] sin;
		logic signed [15:0] cos;
		logic no_rot;
		logic degen;
	} unit_t;

	typedef struct packed {
		logic signed [32:0] tux, tuy, tuz;
		logic signed [31:0] sux, suy, suz;
		logic signed [15:0] ux, uy, uz;
		logic signed [15:0] cos;
		logic no_rot;
		logic degen;
	} m1_t;

	typedef struct packed {
		logic signed [47:0] pxx, pxy, pxz, pyy, pyz, pzz;
		logic signed [31:0] sux, suy, suz;
		logic signed [15:0] cos;
		logic no_rot;
		logic degen;
	} m2_t;

	typedef struct packed {
		logic signed [47:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
		logic no_rot;
		logic degen;
	} ent_t;

	logic adv;
	logic [N-1:0] vld_q;
	logic signed [15:0] cos_lim_q;

	prod_t prod_s1;
	axis_t axis_s2;
	avrm_pkg::side_t side_s3;
	sq_t sq_s4;
	sqrt_stage_t rad_s5;
	sqrt_stage_t sqrt_s [avrm_pkg::SQRT_STEPS];
	div_stage_t div_init_s;
	div_stage_t div_s [avrm_pkg::DIV_STEPS];
	unit_t unit_s;
	m1_t m1_s;
	m2_t m2_s;
	ent_t ent_s;

	assign adv = !vld_q[N-1] || result.ready;
	assign req.ready = adv;
	assign result.valid = vld_q[N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cos_lim_q <= avrm_pkg::COS_ONE;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[N-2:0], req.valid};
			end
			if (cfg_we) begin
				cos_lim_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1.fy_tz <= req.from_y * req.to_z;
			prod_s1.fz_ty <= req.from_z * req.to_y;
			prod_s1.fz_tx <= req.from_z * req.to_x;
			prod_s1.fx_tz <= req.from_x * req.to_z;
			prod_s1.fx_ty <= req.from_x * req.to_y;
			prod_s1.fy_tx <= req.from_y * req.to_x;
			prod_s1.fx_tx <= req.from_x * req.to_x;
			prod_s1.fy_ty <= req.from_y * req.to_y;
			prod_s1.fz_tz <= req.from_z * req.to_z;
		end
	end

	logic signed [33:0] dot;
	logic signed [33:0] cos_wide;
	logic signed [15:0] cos_clamp;

	always_comb begin
		dot = 34'(prod_s1.fx_tx) + 34'(prod_s1.fy_ty) + 34'(prod_s1.fz_tz);
		cos_wide = (dot + 34'sd8192) >>> 14;
		if (cos_wide > 34'sd16384) begin
			cos_clamp = avrm_pkg::COS_ONE;
		end else if (cos_wide < -34'sd16384) begin
			cos_clamp = -avrm_pkg::COS_ONE;
		end else begin
			cos_clamp = cos_wide[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			axis_s2.ax <= 33'(prod_s1.fy_tz) - 33'(prod_s1.fz_ty);
			axis_s2.ay <= 33'(prod_s1.fz_tx) - 33'(prod_s1.fx_tz);
			axis_s2.az <= 33'(prod_s1.fx_ty) - 33'(prod_s1.fy_tx);
			axis_s2.cos <= cos_clamp;
			axis_s2.no_rot <= cos_clamp >= cos_lim_q;
		end
	end

	logic signed [32:0] nax, nay, naz;

	always_comb begin
		nax = -axis_s2.ax;
		nay = -axis_s2.ay;
		naz = -axis_s2.az;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.abs_x <= axis_s2.ax[32] ? nax[31:0] : axis_s2.ax[31:0];
			side_s3.abs_y <= axis_s2.ay[32] ? nay[31:0] : axis_s2.ay[31:0];
			side_s3.abs_z <= axis_s2.az[32] ? naz[31:0] : axis_s2.az[31:0];
			side_s3.neg <= {axis_s2.az[32], axis_s2.ay[32], axis_s2.ax[32]};
			side_s3.cos <= axis_s2.cos;
			side_s3.no_rot <= axis_s2.no_rot;
			side_s3.degen <= (axis_s2.ax == '0) && (axis_s2.ay == '0) && (axis_s2.az == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4.sq_x <= 64'(side_s3.abs_x) * 64'(side_s3.abs_x);
			sq_s4.sq_y <= 64'(side_s3.abs_y) * 64'(side_s3.abs_y);
			sq_s4.sq_z <= 64'(side_s3.abs_z) * 64'(side_s3.abs_z);
			sq_s4.cc <= 29'(side_s3.cos * side_s3.cos);
			sq_s4.side <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s5.len_rad <= sq_s4.sq_x + sq_s4.sq_y + sq_s4.sq_z;
			rad_s5.sin_rad <= avrm_pkg::RAD_ONE - sq_s4.cc;
			rad_s5.len_acc <= '0;
			rad_s5.sin_acc <= '0;
			rad_s5.side <= sq_s4.side;
		end
	end

	for (genvar i = 0; i < avrm_pkg::SQRT_STEPS; i++) begin : g_sqrt
		sqrt_stage_t prv;
		sqrt_stage_t nxt;
		logic [63:0] sin_ext;
		if (i == 0) begin : g_first
			assign prv = rad_s5;
		end else begin : g_next
			assign prv = sqrt_s[i-1];
		end
		assign sin_ext = 64'(prv.sin_rad);
		always_comb begin
			nxt = prv;
			nxt.len_acc = avrm_pkg::sqrt_step(prv.len_acc, prv.len_rad[63-2*i -: 2]);
			nxt.sin_acc = avrm_pkg::sqrt_step(prv.sin_acc, sin_ext[63-2*i -: 2]);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_s[i] <= nxt;
			end
		end
	end

	logic [31:0] len_fix;
	avrm_pkg::side_t sqrt_side;

	assign sqrt_side = sqrt_s[avrm_pkg::SQRT_STEPS-1].side;
	assign len_fix = (sqrt_s[avrm_pkg::SQRT_STEPS-1].len_acc.root == '0) ? 32'd1 :
		sqrt_s[avrm_pkg::SQRT_STEPS-1].len_acc.root;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_init_s.qx.rem <= 47'({sqrt_side.abs_x, 14'b0}) + 47'(len_fix[31:1]);
			div_init_s.qy.rem <= 47'({sqrt_side.abs_y, 14'b0}) + 47'(len_fix[31:1]);
			div_init_s.qz.rem <= 47'({sqrt_side.abs_z, 14'b0}) + 47'(len_fix[31:1]);
			div_init_s.qx.quo <= '0;
			div_init_s.qy.quo <= '0;
			div_init_s.qz.quo <= '0;
			div_init_s.len <= len_fix;
			div_init_s.sin <= sqrt_s[avrm_pkg::SQRT_STEPS-1].sin_acc.root[14:0];
			div_init_s.side <= sqrt_side;
		end
	end

	for (genvar i = 0; i < avrm_pkg::DIV_STEPS; i++) begin : g_div
		div_stage_t prv;
		div_stage_t nxt;
		logic [46:0] dsh;
		if (i == 0) begin : g_first
			assign prv = div_init_s;
		end else begin : g_next
			assign prv = div_s[i-1];
		end
		assign dsh = 47'(prv.len) << (avrm_pkg::DIV_STEPS - 1 - i);
		always_comb begin
			nxt = prv;
			nxt.qx = avrm_pkg::div_step(prv.qx, dsh);
			nxt.qy = avrm_pkg::div_step(prv.qy, dsh);
			nxt.qz = avrm_pkg::div_step(prv.qz, dsh);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[i] <= nxt;
			end
		end
	end

	div_stage_t dl;
	logic signed [15:0] qx_s, qy_s, qz_s;

	assign dl = div_s[avrm_pkg::DIV_STEPS-1];
	assign qx_s = $signed({1'b0, dl.qx.quo});
	assign qy_s = $signed({1'b0, dl.qy.quo});
	assign qz_s = $signed({1'b0, dl.qz.quo});

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_s.ux <= dl.side.neg[0] ? -qx_s : qx_s;
			unit_s.uy <= dl.side.neg[1] ? -qy_s : qy_s;
			unit_s.uz <= dl.side.neg[2] ? -qz_s : qz_s;
			unit_s.t <= 17'sd16384 - 17'(dl.side.cos);
			unit_s.sin <= $signed({1'b0, dl.sin});
			unit_s.cos <= dl.side.cos;
			unit_s.no_rot <= dl.side.no_rot;
			unit_s.degen <= dl.side.degen;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s.tux <= unit_s.t * unit_s.ux;
			m1_s.tuy <= unit_s.t * unit_s.uy;
			m1_s.tuz <= unit_s.t * unit_s.uz;
			m1_s.sux <= unit_s.sin * unit_s.ux;
			m1_s.suy <= unit_s.sin * unit_s.uy;
			m1_s.suz <= unit_s.sin * unit_s.uz;
			m1_s.ux <= unit_s.ux;
			m1_s.uy <= unit_s.uy;
			m1_s.uz <= unit_s.uz;
			m1_s.cos <= unit_s.cos;
			m1_s.no_rot <= unit_s.no_rot;
			m1_s.degen <= unit_s.degen;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m2_s.pxx <= 48'(m1_s.tux * m1_s.ux);
			m2_s.pxy <= 48'(m1_s.tux * m1_s.uy);
			m2_s.pxz <= 48'(m1_s.tux * m1_s.uz);
			m2_s.pyy <= 48'(m1_s.tuy * m1_s.uy);
			m2_s.pyz <= 48'(m1_s.tuy * m1_s.uz);
			m2_s.pzz <= 48'(m1_s.tuz * m1_s.uz);
			m2_s.sux <= m1_s.sux;
			m2_s.suy <= m1_s.suy;
			m2_s.suz <= m1_s.suz;
			m2_s.cos <= m1_s.cos;
			m2_s.no_rot <= m1_s.no_rot;
			m2_s.degen <= m1_s.degen;
		end
	end

	logic signed [47:0] cq, sxq, syq, szq;

	assign cq = {{4{m2_s.cos[15]}}, m2_s.cos, 28'b0};
	assign sxq = {{2{m2_s.sux[31]}}, m2_s.sux, 14'b0};
	assign syq = {{2{m2_s.suy[31]}}, m2_s.suy, 14'b0};
	assign szq = {{2{m2_s.suz[31]}}, m2_s.suz, 14'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s.e00 <= m2_s.pxx + cq;
			ent_s.e01 <= m2_s.pxy - szq;
			ent_s.e02 <= m2_s.pxz + syq;
			ent_s.e10 <= m2_s.pxy + szq;
			ent_s.e11 <= m2_s.pyy + cq;
			ent_s.e12 <= m2_s.pyz - sxq;
			ent_s.e20 <= m2_s.pxz - syq;
			ent_s.e21 <= m2_s.pyz + sxq;
			ent_s.e22 <= m2_s.pzz + cq;
			ent_s.no_rot <= m2_s.no_rot;
			ent_s.degen <= m2_s.degen;
		end
	end

	logic ident;
	logic [avrm_pkg::ROW_W-1:0] row0_d, row1_d, row2_d;

	assign ident = ent_s.no_rot || ent_s.degen;
	assign row0_d = avrm_pkg::ROW_W'({avrm_pkg::to_word(ent_s.e02), avrm_pkg::to_word(ent_s.e01),
		avrm_pkg::to_word(ent_s.e00)});
	assign row1_d = avrm_pkg::ROW_W'({avrm_pkg::to_word(ent_s.e12), avrm_pkg::to_word(ent_s.e11),
		avrm_pkg::to_word(ent_s.e10)});
	assign row2_d = avrm_pkg::ROW_W'({avrm_pkg::to_word(ent_s.e22), avrm_pkg::to_word(ent_s.e21),
		avrm_pkg::to_word(ent_s.e20)});

	always_ff @(posedge clk) begin
		if (adv) begin
			result.row0_packed <= ident ? avrm_pkg::ID_ROW0 : row0_d;
			result.row1_packed <= ident ? avrm_pkg::ID_ROW1 : row1_d;
			result.row2_packed <= ident ? avrm_pkg::ID_ROW2 : row2_d;
			result.rotated <= !ident;
			result.degenerate <= !ent_s.no_rot && ent_s.degen;
		end
	end

endmodule

// File: rtl/avrm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the vector alignment rotation matrix core, with its bind.
module avrm_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic res_valid,
	input logic res_ready,
	input logic [avrm_pkg::ROW_W-1:0] row0,
	input logic [avrm_pkg::ROW_W-1:0] row1,
	input logic [avrm_pkg::ROW_W-1:0] row2,
	input logic rotated,
	input logic degenerate
);

	// An empty output stage must never hold back a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !res_valid) |-> req_ready)
		else $error("request stalled while the output stage is empty");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(rotated && degenerate))
		else $error("rotated and degenerate both set");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !rotated) |-> (row0 == avrm_pkg::ID_ROW0 && row1 == avrm_pkg::ID_ROW1 &&
		row2 == avrm_pkg::ID_ROW2))
		else $error("unrotated result is not the identity matrix");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(row0) && $stable(row1) &&
		$stable(row2) && $stable(rotated) && $stable(degenerate)))
		else $error("stalled result changed");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind align_vector_rotation_matrix_core avrm_checker u_avrm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.row0(result.row0_packed),
	.row1(result.row1_packed),
	.row2(result.row2_packed),
	.rotated(result.rotated),
	.degenerate(result.degenerate)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Rodrigues rotation matrix core.
module tb;

	localparam int LATENCY = 58;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_RANDOM = 900;

	typedef struct packed {
		logic [15:0] fx, fy, fz, tx, ty, tz;
	} pair_t;

	typedef struct packed {
		logic [avrm_pkg::ROW_W-1:0] r0, r1, r2;
		logic rot, degen;
	} matrix_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [avrm_pkg::IN_W-1:0] cfg_wdata;

	avrm_req_if req();
	avrm_res_if result();

	align_vector_rotation_matrix_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req.sink),
		.result(result.source)
	);

	matrix_t expected_q[$];
	logic signed [63:0] cos_limit;
	int n_errors;
	int n_requests;
	int n_results;
	int n_rotated;
	int n_degen;
	int idle_cycles;
	bit hold_result;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] round_sat(logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + (64'sd1 <<< 27)) >>> 28;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic logic signed [63:0] unit_axis(logic signed [63:0] a, logic [63:0] len);
		logic [63:0] q;
		logic [63:0] m;
		m = a < 0 ? -a : a;
		q = (m * 16384 + len / 2) / len;
		return a < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic matrix_t rotation_for(pair_t p);
		logic signed [63:0] fx, fy, fz, tx, ty, tz, ax, ay, az, d, c, s, t, ux, uy, uz;
		logic [63:0] len;
		matrix_t m;
		fx = $signed(p.fx); fy = $signed(p.fy); fz = $signed(p.fz);
		tx = $signed(p.tx); ty = $signed(p.ty); tz = $signed(p.tz);
		ax = fy * tz - fz * ty;
		ay = fz * tx - fx * tz;
		az = fx * ty - fy * tx;
		d = fx * tx + fy * ty + fz * tz;
		c = (d + 8192) >>> 14;
		if (c > 16384) c = 16384;
		if (c < -16384) c = -16384;
		m.r0 = {16'h0, 16'h0, 16'h4000};
		m.r1 = {16'h0, 16'h4000, 16'h0};
		m.r2 = {16'h4000, 16'h0, 16'h0};
		m.rot = 1'b0;
		m.degen = 1'b0;
		if (c >= cos_limit) return m;
		if (ax == 0 && ay == 0 && az == 0) begin
			m.degen = 1'b1;
			return m;
		end
		len = int_sqrt(ax * ax + ay * ay + az * az);
		if (len == 0) len = 1;
		ux = unit_axis(ax, len);
		uy = unit_axis(ay, len);
		uz = unit_axis(az, len);
		s = int_sqrt(268435456 - c * c);
		t = 16384 - c;
		m.r0 = {round_sat(t * ux * uz + s * uy * 16384),
			round_sat(t * ux * uy - s * uz * 16384),
			round_sat(t * ux * ux + c * 268435456)};
		m.r1 = {round_sat(t * uy * uz - s * ux * 16384),
			round_sat(t * uy * uy + c * 268435456),
			round_sat(t * ux * uy + s * uz * 16384)};
		m.r2 = {round_sat(t * uz * uz + c * 268435456),
			round_sat(t * uy * uz + s * ux * 16384),
			round_sat(t * ux * uz - s * uy * 16384)};
		m.rot = 1'b1;
		return m;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("tb: mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin
		matrix_t e;
		if (req.valid && req.ready) begin
			expected_q.push_back(rotation_for('{req.from_x, req.from_y, req.from_z,
				req.to_x, req.to_y, req.to_z}));
			n_requests++;
		end
		if (result.valid && result.ready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				e = expected_q.pop_front();
				if (result.row0_packed !== e.r0) report_mismatch("row0", result.row0_packed, e.r0);
				if (result.row1_packed !== e.r1) report_mismatch("row1", result.row1_packed, e.r1);
				if (result.row2_packed !== e.r2) report_mismatch("row2", result.row2_packed, e.r2);
				if (result.rotated !== e.rot) report_mismatch("rotated", result.rotated, e.rot);
				if (result.degenerate !== e.degen)
					report_mismatch("degenerate", result.degenerate, e.degen);
				n_rotated += e.rot;
				n_degen += e.degen;
			end
		end
		if ((req.valid && req.ready) || (result.valid && result.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: watchdog expired with %0d results pending", expected_q.size());
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// The receiver stalls in random bursts, with one long hold early in the run.
	initial begin
		int k;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_result) begin
				result.ready <= 1'b0;
				for (k = 0; k < 200; k++) @(negedge clk);
				hold_result = 1'b0;
				result.ready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic send_pair(pair_t p);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.from_x <= p.fx; req.from_y <= p.fy; req.from_z <= p.fz;
		req.to_x <= p.tx; req.to_y <= p.ty; req.to_z <= p.tz;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain_and_set_limit(logic [15:0] v);
		@(negedge clk);
		req.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cos_limit = $signed(v);
	endtask

	function automatic logic [15:0] rand_comp(int mode);
		if (mode == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int mode;
		int k;
		mode = $urandom_range(0, 9);
		p = '{rand_comp(mode % 2), rand_comp(mode % 2), rand_comp(mode % 2),
			rand_comp(mode % 2), rand_comp(mode % 2), rand_comp(mode % 2)};
		k = $urandom_range(1, 3);
		if (mode == 2) begin
			p.tx = p.fx; p.ty = p.fy; p.tz = p.fz;
		end else if (mode == 3) begin
			p.tx = -p.fx; p.ty = -p.fy; p.tz = -p.fz;
		end else if (mode == 4) begin
			p.tx = 16'(p.fx * k); p.ty = 16'(p.fy * k); p.tz = 16'(p.fz * k);
		end else if (mode == 5) begin
			p.tx = p.fx + 16'($urandom_range(0, 200)) - 16'd100;
		end
		return p;
	endfunction

	// Directed rows: the expected matrix is filled in only where it is obvious.
	typedef struct {
		pair_t p;
		bit known;
		matrix_t m;
	} row_t;

	localparam logic [avrm_pkg::ROW_W-1:0] I0 = {16'h0, 16'h0, 16'h4000};
	localparam logic [avrm_pkg::ROW_W-1:0] I1 = {16'h0, 16'h4000, 16'h0};
	localparam logic [avrm_pkg::ROW_W-1:0] I2 = {16'h4000, 16'h0, 16'h0};

	row_t directed[] = '{
		'{'{16'h4000, 0, 0, 16'h4000, 0, 0}, 1, '{I0, I1, I2, 0, 0}},
		'{'{16'h4000, 0, 0, 16'hC000, 0, 0}, 1, '{I0, I1, I2, 0, 1}},
		'{'{0, 0, 0, 0, 0, 0}, 1, '{I0, I1, I2, 0, 1}},
		'{'{16'h4000, 0, 0, 0, 16'h4000, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{0, 16'h4000, 0, 0, 0, 16'h4000}, 0, '{0, 0, 0, 0, 0}},
		'{'{0, 0, 16'h4000, 16'h4000, 0, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, 1,
			'{I0, I1, I2, 0, 1}},
		'{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 0,
			'{0, 0, 0, 0, 0}},
		'{'{16'h8000, 16'h8000, 0, 16'h7FFF, 16'h8000, 16'h7FFF}, 0, '{0, 0, 0, 0, 0}},
		'{'{16'h2D41, 16'h2D41, 0, 16'h2D41, 16'hD2BF, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{16'h4000, 0, 0, 16'h3FFF, 16'h0100, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{16'h4000, 0, 0, 16'hC001, 16'h0080, 0}, 0, '{0, 0, 0, 0, 0}},
		'{'{16'h0001, 0, 0, 0, 16'h0001, 0}, 0, '{0, 0, 0, 0, 0}}
	};

	initial begin
		int i;
		int k;
		matrix_t m;
		logic [15:0] limits[6] = '{16'hC000, 16'h0000, 16'h3FFF, 16'h2000, 16'hE000, 16'h4000};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		{req.from_x, req.from_y, req.from_z, req.to_x, req.to_y, req.to_z} = '0;
		cos_limit = 16384;
		n_errors = 0;
		n_requests = 0;
		n_results = 0;
		n_rotated = 0;
		n_degen = 0;
		idle_cycles = 0;
		hold_result = 1'b0;
		no_idle = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < directed.size(); i++) begin
			if (directed[i].known) begin
				m = rotation_for(directed[i].p);
				if (m != directed[i].m) report_mismatch("directed table row", i, 0);
			end
			send_pair(directed[i].p);
		end

		hold_result = 1'b1;
		for (i = 0; i < 300; i++) send_pair(rand_pair());

		drain_and_set_limit(limits[0]);
		for (k = 0; k < 6; k++) begin
			for (i = 0; i < N_RANDOM / 6; i++) begin
				if (k == 5 && i > N_RANDOM / 12) no_idle = 1'b1;
				send_pair(rand_pair());
			end
			if (k == 2) begin
				for (i = 0; i < directed.size(); i++) send_pair(directed[i].p);
			end
			if (k < 5) drain_and_set_limit(limits[k + 1]);
		end
		@(negedge clk);
		req.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		$display("tb: %0d requests, %0d results over six cosine limits", n_requests, n_results);
		$display("tb: %0d rotations, %0d degenerate axes", n_rotated, n_degen);
		if (n_errors == 0 && expected_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
